// ===== rtl/sie_pkg.sv =====
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types and constants of the strided interval expander.
// ----------------------------------------------------------------------------
package sie_pkg;

    localparam int MAX_REP_DEF = 64;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MARGIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SHIFT = 8'd1;

    localparam logic [15:0] GAP_MARGIN_RST  = 16'd256;
    localparam logic [4:0]  ALIGN_SHIFT_RST = 5'd0;

    // offsets are 31-bit non-negative values
    localparam int OFS_W = 31;
    localparam int END_W = 32;

    localparam logic [END_W-1:0] LIM31    = 32'h7FFF_FFFF;
    localparam logic [OFS_W-1:0] CLIP_END = 31'h7FFF_FFFE;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic [15:0] gap_margin;
        logic [4:0]  align_shift;
    } sie_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLIP,
        ST_MERGE,
        ST_ROW,
        ST_FLUSH
    } sie_state_t;

endpackage

// ===== rtl/strided_interval_expander_core.sv =====
// ----------------------------------------------------------------------------
// strided_interval_expander_core
// Expands one strided region into its aligned, merged byte intervals.
// ----------------------------------------------------------------------------
// One region is taken while s_tready is high; the block then stays busy until
// the last interval (m_tlast) has been loaded into the output register. A
// region passes through the set-up states (repeat-span multiply, end-overflow
// clip, gap merge check), then through the shared row adder/align unit at one
// repeat per cycle, stalling while a finished interval waits for the output
// register, then hands over the final interval once that register is free. The
// repeat count is saturated at MAX_REP and taken as one when the region is
// clipped or merged. Regions with a negative start, zero width or zero repeats
// are dropped in the accept cycle; regions left empty by the end clip are
// dropped in the clip state. Configuration writes are taken in any cycle and
// belong in idle periods.
module strided_interval_expander_core #(
    parameter int MAX_REP = sie_pkg::MAX_REP_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // first_start[31:0], span_width[62:32], row_stride[93:63],
    // repeat_count[100:94], zero fill above
    input  logic [sie_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // seg_start[30:0], seg_end[62:31], zero fill above
    output logic [sie_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sie_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sie_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sie_pkg::*;

    localparam int REP_W  = $clog2(MAX_REP + 1);
    localparam int PROD_W = OFS_W + REP_W;
    localparam int SUM_W  = PROD_W + 2;

    sie_cfg_t cfg;

    sie_state_t state_reg, state_next;

    logic [OFS_W-1:0]  start_reg,  start_next;
    logic [OFS_W-1:0]  width_reg,  width_next;
    logic [OFS_W-1:0]  stride_reg, stride_next;
    logic [REP_W-1:0]  rep_reg,    rep_next;
    logic [PROD_W-1:0] prod_reg,   prod_next;
    logic [OFS_W-1:0]  cur_reg,    cur_next;
    logic [REP_W-1:0]  cnt_reg,    cnt_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [OFS_W-1:0]  pend_start_reg, pend_start_next;
    logic [END_W-1:0]  pend_end_reg,   pend_end_next;

    logic              out_valid_reg, out_valid_next;
    logic [OFS_W-1:0]  out_start_reg, out_start_next;
    logic [END_W-1:0]  out_end_reg,   out_end_next;
    logic              out_last_reg,  out_last_next;

    logic [END_W-1:0]  in_first;
    logic [OFS_W-1:0]  in_width;
    logic [OFS_W-1:0]  in_stride;
    logic [6:0]        in_rep;
    logic [REP_W-1:0]  rep_sat;

    logic [SUM_W-1:0]  span_end;
    logic [END_W-1:0]  merge_lhs;
    logic [OFS_W-1:0]  row_seg_start;
    logic [END_W-1:0]  row_seg_end;
    logic              out_free;
    logic              new_seg;

    sie_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sie_row_align u_row (
        .row_start   (cur_reg),
        .row_width   (width_reg),
        .align_shift (cfg.align_shift),
        .seg_start   (row_seg_start),
        .seg_end     (row_seg_end)
    );

    assign in_first  = s_tdata[31:0];
    assign in_width  = s_tdata[62:32];
    assign in_stride = s_tdata[93:63];
    assign in_rep    = s_tdata[100:94];
    assign rep_sat   = (in_rep > 7'(MAX_REP)) ? REP_W'(MAX_REP) : REP_W'(in_rep);

    assign span_end  = SUM_W'(start_reg) + SUM_W'(prod_reg) + SUM_W'(width_reg);
    assign merge_lhs = END_W'(width_reg) + END_W'(cfg.gap_margin);
    assign out_free  = !out_valid_reg || m_tready;
    assign new_seg   = !pend_valid_reg || (END_W'(row_seg_start) > pend_end_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_TDATA_W - OFS_W - END_W)'(0), out_end_reg, out_start_reg};

    always_comb begin
        state_next      = state_reg;
        start_next      = start_reg;
        width_next      = width_reg;
        stride_next     = stride_reg;
        rep_next        = rep_reg;
        prod_next       = prod_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                start_next  = in_first[OFS_W-1:0];
                width_next  = in_width;
                stride_next = in_stride;
                rep_next    = rep_sat;
                if (s_tvalid && !in_first[31] && in_width != '0 && in_rep != '0) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(stride_reg) * PROD_W'(rep_reg - REP_W'(1));
                state_next = ST_CLIP;
            end
            ST_CLIP: begin
                state_next = ST_MERGE;
                if (span_end >= SUM_W'(LIM31)) begin
                    width_next = CLIP_END - start_reg;
                    rep_next   = REP_W'(1);
                    prod_next  = '0;
                    if (start_reg >= CLIP_END) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MERGE: begin
                if (merge_lhs > END_W'(stride_reg)) begin
                    width_next = width_reg + prod_reg[OFS_W-1:0];
                    rep_next   = REP_W'(1);
                end
                cur_next   = start_reg;
                cnt_next   = '0;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                if (!(new_seg && pend_valid_reg) || out_free) begin
                    if (new_seg) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_start_next = pend_start_reg;
                            out_end_next   = pend_end_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_start_next = row_seg_start;
                    end
                    pend_end_next = row_seg_end;
                    cur_next      = cur_reg + stride_reg;
                    cnt_next      = cnt_reg + REP_W'(1);
                    if (cnt_reg + REP_W'(1) == rep_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_start_next  = pend_start_reg;
                    out_end_next    = pend_end_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg      <= start_next;
        width_reg      <= width_next;
        stride_reg     <= stride_next;
        rep_reg        <= rep_next;
        prod_reg       <= prod_next;
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_last_reg   <= out_last_next;
    end

`ifndef SYNTHESIS
    // no interval left pending once idle
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending interval left while idle");

    // flush always has an interval to hand over
    a_flush_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> pend_valid_reg)
        else $error("flush without pending interval");

    // row counter stays inside the repeat count
    a_row_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) |-> (cnt_reg < rep_reg))
        else $error("row counter beyond repeat count");

    // every emitted interval is non-empty
    a_seg_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_end_reg > END_W'(out_start_reg)))
        else $error("empty interval emitted");
`endif

endmodule

// ===== rtl/sie_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sie_cfg_regs
// Configuration register file: gap margin and alignment shift.
// ----------------------------------------------------------------------------
module sie_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sie_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sie_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sie_pkg::sie_cfg_t                 cfg
);
    import sie_pkg::*;

    sie_cfg_t cfg_reg;
    sie_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GAP_MARGIN:  cfg_next.gap_margin  = cfg_data[15:0];
                CFG_ALIGN_SHIFT: cfg_next.align_shift = cfg_data[4:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_margin  <= GAP_MARGIN_RST;
            cfg_reg.align_shift <= ALIGN_SHIFT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/sie_row_align.sv =====
// ----------------------------------------------------------------------------
// sie_row_align
// Row unit: end of one repeat and rounding of start down, end up.
// ----------------------------------------------------------------------------
module sie_row_align (
    input  logic [sie_pkg::OFS_W-1:0] row_start,
    input  logic [sie_pkg::OFS_W-1:0] row_width,
    input  logic [4:0]                align_shift,
    output logic [sie_pkg::OFS_W-1:0] seg_start,
    output logic [sie_pkg::END_W-1:0] seg_end
);
    import sie_pkg::*;

    logic [END_W:0]   unit;
    logic [END_W-1:0] mask;
    logic [END_W-1:0] row_end;
    logic [END_W:0]   end_up;

    assign unit    = (END_W+1)'(1) << align_shift;
    assign mask    = END_W'(unit - (END_W+1)'(1));
    assign row_end = END_W'(row_start) + END_W'(row_width);
    assign end_up  = ({1'b0, row_end} + {1'b0, mask}) & ~{1'b0, mask};

    assign seg_start = row_start & ~mask[OFS_W-1:0];
    assign seg_end   = end_up[END_W-1:0];

endmodule
